>>> rtl/fcdw_pkg.sv
// Package for the FIR convolver with dry/wet mix.
// Holds the item classification codes, the back-end state type and fixed constants.
// No dependencies; the front end, the back end and the top refer to it by scoped names.
package fcdw_pkg;

	// Fixed field widths of the item and register format.
	localparam int IR_LEN_W  = 11;
	localparam int MIX_W     = 16;
	localparam int TAP_IDX_W = 10;
	localparam int ACC_W     = 64;

	// Unity wet fraction in Q15, one bit wider than the register.
	localparam logic [MIX_W:0] MIX_ONE = 17'd32768;

	// Register reset values.
	localparam logic [IR_LEN_W-1:0] IR_LENGTH_RST = 11'd1024;
	localparam logic [MIX_W-1:0]    WET_MIX_RST   = 16'd32768;

	// Register indexes, taken from paddr[2].
	localparam logic REG_IR_LENGTH = 1'b0;
	localparam logic REG_WET_MIX   = 1'b1;

	// Function code of an input item.
	localparam logic FUNC_LOAD = 1'b1;

	// Classification made by the front end.
	typedef enum logic [1:0] {
		OP_LOAD,
		OP_PASS,
		OP_FILT
	} op_t;

	// Control part of a queued item.
	typedef struct packed {
		op_t                 op;
		logic                tap_ok;
		logic [IR_LEN_W-1:0] len;
		logic [MIX_W-1:0]    mix;
	} item_ctrl_t;

	// Back-end sequencer states.
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HIST,
		ST_MAC,
		ST_DRAIN,
		ST_MIX1,
		ST_MIX2,
		ST_MIX3,
		ST_DONE
	} st_t;

endpackage

>>> rtl/fcdw_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the tap store and the sample history. No dependencies.
module fcdw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/fcdw_queue.sv
// Two-entry queue between the front end and the back end.
// Depends on nothing; the payload is an opaque packed vector.
module fcdw_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic             empty,
	output logic             full,
	output logic [WIDTH-1:0] head
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	assign empty = (count_q == 2'd0);
	assign full  = (count_q == 2'd2);
	assign head  = mem_q[rd_ptr_q];

	// Pointer and occupancy tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// Entry storage needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

>>> rtl/fcdw_front.sv
// Front end: configuration registers, input acceptance and item classification.
// Depends on fcdw_pkg; feeds fcdw_queue.
module fcdw_front #(
	parameter int MAX_TAPS    = 1024,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [2:0]                     paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           func,
	input  logic [fcdw_pkg::TAP_IDX_W-1:0] tap_index,
	input  logic signed [SAMPLE_BITS-1:0]  value,
	input  logic                           q_full,
	input  logic                           clearing,
	output logic                           push,
	output logic [$bits(fcdw_pkg::item_ctrl_t)+fcdw_pkg::TAP_IDX_W+SAMPLE_BITS-1:0] push_data
);

	logic [fcdw_pkg::IR_LEN_W-1:0] ir_length_q;
	logic [fcdw_pkg::MIX_W-1:0]    wet_mix_q;
	logic [fcdw_pkg::IR_LEN_W-1:0] len_eff;
	logic [fcdw_pkg::MIX_W-1:0]    mix_eff;
	logic                          wr_en;
	fcdw_pkg::item_ctrl_t          ctrl;

	// Register write on the access phase of an APB transfer.
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ir_length_q <= fcdw_pkg::IR_LENGTH_RST;
			wet_mix_q   <= fcdw_pkg::WET_MIX_RST;
		end else if (wr_en) begin
			if (paddr[2] == fcdw_pkg::REG_IR_LENGTH) begin
				ir_length_q <= pwdata[fcdw_pkg::IR_LEN_W-1:0];
			end else begin
				wet_mix_q <= pwdata[fcdw_pkg::MIX_W-1:0];
			end
		end
	end

	// Register read-back.
	always_comb begin
		if (paddr[2] == fcdw_pkg::REG_IR_LENGTH) begin
			prdata = 32'(ir_length_q);
		end else begin
			prdata = 32'(wet_mix_q);
		end
	end

	// Input transfers are held off while the queue is full or taps are being cleared.
	assign in_stall = q_full || clearing;
	assign push     = in_valid && !in_stall;

	// Clamp the length and the mix, then classify the item.
	always_comb begin
		if (32'(ir_length_q) > 32'(MAX_TAPS)) begin
			len_eff = fcdw_pkg::IR_LEN_W'(MAX_TAPS);
		end else begin
			len_eff = ir_length_q;
		end
		if (wet_mix_q > fcdw_pkg::MIX_ONE[fcdw_pkg::MIX_W-1:0]) begin
			mix_eff = fcdw_pkg::MIX_ONE[fcdw_pkg::MIX_W-1:0];
		end else begin
			mix_eff = wet_mix_q;
		end

		ctrl.len    = len_eff;
		ctrl.mix    = mix_eff;
		ctrl.tap_ok = (32'(tap_index) < 32'(MAX_TAPS));
		if (func == fcdw_pkg::FUNC_LOAD) begin
			ctrl.op = fcdw_pkg::OP_LOAD;
		end else if ((len_eff == '0) || (mix_eff == '0)) begin
			ctrl.op = fcdw_pkg::OP_PASS;
		end else begin
			ctrl.op = fcdw_pkg::OP_FILT;
		end
	end

	assign push_data = {ctrl, tap_index, value};

endmodule

>>> rtl/fcdw_back.sv
// Back end: tap clearing after reset, tap loads, history writes, the shared
// multiply-accumulate, the dry/wet mix and the output register.
// Depends on fcdw_pkg and fcdw_ram; takes items from fcdw_queue.
module fcdw_back #(
	parameter int MAX_TAPS    = 1024,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_empty,
	input  logic [$bits(fcdw_pkg::item_ctrl_t)+fcdw_pkg::TAP_IDX_W+SAMPLE_BITS-1:0] q_head,
	output logic                          pop,
	output logic                          clearing,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] sample_out
);

	localparam int SB  = SAMPLE_BITS;
	localparam int F   = SAMPLE_BITS - 1;
	localparam int AW  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int CW  = AW + 1;
	localparam int DRW = SAMPLE_BITS + fcdw_pkg::MIX_W + 2;
	localparam logic [fcdw_pkg::ACC_W-1:0] ROUND = 64'd1 << (F + 14);
	localparam logic signed [63:0] SAT_HI = (64'sd1 <<< F) - 64'sd1;
	localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

	// Unpacked head of the queue.
	fcdw_pkg::item_ctrl_t           h_ctrl;
	logic [fcdw_pkg::TAP_IDX_W-1:0] h_tap_index;
	logic [SB-1:0]                  h_value;

	fcdw_pkg::st_t state_q, state_d;

	// Per-item registers and sequencing counters.
	logic [CW-1:0]              len_q;
	logic [fcdw_pkg::MIX_W-1:0] mix_q;
	logic [SB-1:0]              val_q;
	logic [AW-1:0]              cur_pos_q;
	logic [AW-1:0]              pos_q;
	logic [CW-1:0]              fill_q;
	logic [CW-1:0]              j_q;
	logic [AW-1:0]              rd_q;
	logic [AW-1:0]              clr_q;
	logic [CW-1:0]              pos_nxt;

	// Multiply-accumulate pipeline.
	logic                     iss_s1;
	logic                     hv_s1;
	logic                     v_s2;
	logic signed [2*SB-1:0]   prod_s2;
	logic signed [2*SB-1:0]   prod_w;
	logic [fcdw_pkg::ACC_W-1:0] acc_q;
	logic [SB-1:0]            hist_rd;
	logic [SB-1:0]            tap_rd;

	// Mix arithmetic.
	logic [47:0]              mlo_q;
	logic [31:0]              mhi_q;
	logic [47:0]              mhi_full;
	logic [fcdw_pkg::MIX_W:0] dry_w;
	logic signed [DRW-1:0]    mdry_q;
	logic [fcdw_pkg::ACC_W-1:0] t1_q;
	logic [fcdw_pkg::ACC_W-1:0] t2_q;
	logic [fcdw_pkg::ACC_W-1:0] tot_q;
	logic signed [63:0]       res_w;
	logic [SB-1:0]            sat_w;

	// Control strobes from the output decode.
	logic          out_free;
	logic          tap_we;
	logic [AW-1:0] tap_waddr;
	logic [SB-1:0] tap_wdata;
	logic          hist_we;
	logic          issue;
	logic          out_load;
	logic [SB-1:0] out_data;

	// Output register.
	logic          out_valid_q;
	logic [SB-1:0] sample_out_q;

	assign {h_ctrl, h_tap_index, h_value} = q_head;
	assign out_free = !out_valid_q || !out_stall;
	assign clearing = (state_q == fcdw_pkg::ST_CLEAR);

	// Tap store, zeroed by the clearing pass after reset.
	fcdw_ram #(
		.WIDTH (SB),
		.DEPTH (MAX_TAPS)
	) u_tap_ram (
		.clk   (clk),
		.we    (tap_we),
		.waddr (tap_waddr),
		.wdata (tap_wdata),
		.raddr (j_q[AW-1:0]),
		.rdata (tap_rd)
	);

	// Sample history; entries at or above the fill count read as zero.
	fcdw_ram #(
		.WIDTH (SB),
		.DEPTH (MAX_TAPS)
	) u_hist_ram (
		.clk   (clk),
		.we    (hist_we),
		.waddr (cur_pos_q),
		.wdata (val_q),
		.raddr (rd_q),
		.rdata (hist_rd)
	);

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			fcdw_pkg::ST_CLEAR: begin
				if (clr_q == AW'(MAX_TAPS - 1)) begin
					state_d = fcdw_pkg::ST_IDLE;
				end
			end
			fcdw_pkg::ST_IDLE: begin
				if (pop && (h_ctrl.op == fcdw_pkg::OP_FILT)) begin
					state_d = fcdw_pkg::ST_HIST;
				end
			end
			fcdw_pkg::ST_HIST: state_d = fcdw_pkg::ST_MAC;
			fcdw_pkg::ST_MAC: begin
				if (j_q == (len_q - CW'(1))) begin
					state_d = fcdw_pkg::ST_DRAIN;
				end
			end
			fcdw_pkg::ST_DRAIN: begin
				if (!iss_s1 && !v_s2) begin
					state_d = fcdw_pkg::ST_MIX1;
				end
			end
			fcdw_pkg::ST_MIX1: state_d = fcdw_pkg::ST_MIX2;
			fcdw_pkg::ST_MIX2: state_d = fcdw_pkg::ST_MIX3;
			fcdw_pkg::ST_MIX3: state_d = fcdw_pkg::ST_DONE;
			fcdw_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = fcdw_pkg::ST_IDLE;
				end
			end
			default: state_d = fcdw_pkg::ST_IDLE;
		endcase
	end

	// Output decode of the sequencer.
	always_comb begin
		pop       = 1'b0;
		tap_we    = 1'b0;
		tap_waddr = clr_q;
		tap_wdata = '0;
		hist_we   = 1'b0;
		issue     = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			fcdw_pkg::ST_CLEAR: tap_we = 1'b1;
			fcdw_pkg::ST_IDLE: begin
				if (!q_empty && ((h_ctrl.op != fcdw_pkg::OP_PASS) || out_free)) begin
					pop = 1'b1;
					if ((h_ctrl.op == fcdw_pkg::OP_LOAD) && h_ctrl.tap_ok) begin
						tap_we    = 1'b1;
						tap_waddr = AW'(h_tap_index);
						tap_wdata = h_value;
					end
					if (h_ctrl.op == fcdw_pkg::OP_PASS) begin
						out_load = 1'b1;
					end
				end
			end
			fcdw_pkg::ST_HIST: hist_we = 1'b1;
			fcdw_pkg::ST_MAC:  issue = 1'b1;
			fcdw_pkg::ST_DONE: out_load = out_free;
			default: ;
		endcase
	end

	// Rounding shift and saturation of the mixed sum.
	always_comb begin
		res_w = $signed(tot_q) >>> (F + 15);
		if (res_w > SAT_HI) begin
			sat_w = SAT_HI[SB-1:0];
		end else if (res_w < SAT_LO) begin
			sat_w = SAT_LO[SB-1:0];
		end else begin
			sat_w = res_w[SB-1:0];
		end
		if (state_q == fcdw_pkg::ST_DONE) begin
			out_data = sat_w;
		end else begin
			out_data = h_value;
		end
	end

	assign pos_nxt  = {1'b0, cur_pos_q} + CW'(1);
	assign prod_w   = $signed(hist_rd) * $signed(tap_rd);
	assign mhi_full = acc_q[63:32] * mix_q;
	assign dry_w    = fcdw_pkg::MIX_ONE - {1'b0, mix_q};

	// Control state: sequencer, counters, positions and valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fcdw_pkg::ST_CLEAR;
			clr_q       <= '0;
			pos_q       <= '0;
			fill_q      <= '0;
			j_q         <= '0;
			rd_q        <= '0;
			iss_s1      <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			iss_s1  <= issue;
			v_s2    <= iss_s1;

			if (state_q == fcdw_pkg::ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end

			// A tap load empties the history and rewinds the write position.
			if (pop && (h_ctrl.op == fcdw_pkg::OP_LOAD)) begin
				pos_q  <= '0;
				fill_q <= '0;
			end

			// History write: advance the position and extend the fill count.
			if (state_q == fcdw_pkg::ST_HIST) begin
				if (pos_nxt > fill_q) begin
					fill_q <= pos_nxt;
				end
				if (pos_nxt >= len_q) begin
					pos_q <= '0;
				end else begin
					pos_q <= pos_nxt[AW-1:0];
				end
				j_q  <= '0;
				rd_q <= cur_pos_q;
			end

			// Walk taps forwards and history backwards, wrapping at the length.
			if (state_q == fcdw_pkg::ST_MAC) begin
				j_q <= j_q + CW'(1);
				if (rd_q == '0) begin
					rd_q <= AW'(len_q - CW'(1));
				end else begin
					rd_q <= rd_q - AW'(1);
				end
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers: no reset needed.
	always_ff @(posedge clk) begin
		if (pop) begin
			len_q <= CW'(h_ctrl.len);
			mix_q <= h_ctrl.mix;
			val_q <= h_value;
			if ({1'b0, pos_q} < CW'(h_ctrl.len)) begin
				cur_pos_q <= pos_q;
			end else begin
				cur_pos_q <= '0;
			end
		end

		hv_s1   <= ({1'b0, rd_q} < fill_q);
		prod_s2 <= hv_s1 ? prod_w : '0;

		if (state_q == fcdw_pkg::ST_HIST) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + fcdw_pkg::ACC_W'(prod_s2);
		end

		// Wet product split into two halves, dry product alongside.
		if (state_q == fcdw_pkg::ST_MIX1) begin
			mlo_q  <= acc_q[31:0] * mix_q;
			mhi_q  <= mhi_full[31:0];
			mdry_q <= $signed(val_q) * $signed({1'b0, dry_w});
		end
		if (state_q == fcdw_pkg::ST_MIX2) begin
			t1_q <= fcdw_pkg::ACC_W'(mlo_q) + {mhi_q, 32'd0};
			t2_q <= (fcdw_pkg::ACC_W'(mdry_q) << F) + ROUND;
		end
		if (state_q == fcdw_pkg::ST_MIX3) begin
			tot_q <= t1_q + t2_q;
		end

		if (out_load) begin
			sample_out_q <= out_data;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;

endmodule

>>> rtl/fir_convolver_dry_wet.sv
// FIR convolver with dry/wet mix. A filtered sample passes through the history
// write, the multiply-accumulate over the active taps and the mix; a bypassed one
// goes straight to the output register. Filtered samples are handled one at a
// time by the single shared multiply-accumulate; the two-entry queue takes further
// items meanwhile until full. After reset the tap store is cleared with no input
// taken; configuration writes are accepted throughout.
module fir_convolver_dry_wet #(
	parameter int MAX_TAPS    = 1024,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [2:0]                     paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           func,
	input  logic [fcdw_pkg::TAP_IDX_W-1:0] tap_index,
	input  logic signed [SAMPLE_BITS-1:0]  value,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [SAMPLE_BITS-1:0]  sample_out
);

	localparam int QW = $bits(fcdw_pkg::item_ctrl_t) + fcdw_pkg::TAP_IDX_W + SAMPLE_BITS;

	logic          push;
	logic          pop;
	logic          q_empty;
	logic          q_full;
	logic          clearing;
	logic [QW-1:0] push_data;
	logic [QW-1:0] q_head;

	// Front end: registers and classification.
	fcdw_front #(
		.MAX_TAPS    (MAX_TAPS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.tap_index (tap_index),
		.value     (value),
		.q_full    (q_full),
		.clearing  (clearing),
		.push      (push),
		.push_data (push_data)
	);

	// Queue decoupling the two halves.
	fcdw_queue #(
		.WIDTH (QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.empty     (q_empty),
		.full      (q_full),
		.head      (q_head)
	);

	// Back end: filtering, mixing and result delivery.
	fcdw_back #(
		.MAX_TAPS    (MAX_TAPS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_head     (q_head),
		.pop        (pop),
		.clearing   (clearing),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sample_out (sample_out)
	);

	// The back end never takes an item from an empty queue.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty)
		else $error("item taken from an empty queue");

	// No item enters the queue during the tap clearing pass.
	a_no_push_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !push)
		else $error("item accepted while taps are being cleared");

	// When the clearing pass ends the queue holds nothing.
	a_clear_end_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clearing) |-> q_empty)
		else $error("queue not empty at the end of the clearing pass");

	// A full queue takes no further item.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !push)
		else $error("queue overflow");

endmodule
